// File: rtl/bdew_pkg.sv
// Shared types and constants for the binary dilate/erode window block.
// No dependencies; every other file of the block but bdew_ram imports this package.
package bdew_pkg;

    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int KERNEL_W    = 3;
    localparam int COORD_W     = 10;
    localparam int PIXEL_W     = 8;
    localparam int MAX_ROWS    = 1024;

    localparam logic [PIXEL_W-1:0] PIX_ZERO = 8'd0;
    localparam logic [PIXEL_W-1:0] PIX_FULL = 8'd255;

    // Bit positions inside the two-bit flag kept for every pixel.
    localparam int FLAG_ZERO_BIT = 0;
    localparam int FLAG_FULL_BIT = 1;

    localparam logic [CFG_DATA_W-1:0] RST_WIDTH  = 11'd640;
    localparam logic [CFG_DATA_W-1:0] RST_HEIGHT = 11'd480;
    localparam logic [KERNEL_W-1:0]   RST_KERNEL = 3'd3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_KERNEL = 2'd2,
        CFG_MODE   = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        OP_DILATE = 1'b0,
        OP_ERODE  = 1'b1
    } t_op;

    // Control shared by every cell of the window row.
    typedef struct packed {
        logic shift;      // a new column enters the row this cycle
        logic want_zero;  // look for zero flags (erode) rather than full flags
    } t_cell_ctl;

endpackage

// File: rtl/binary_dilate_erode_window.sv
// Binary dilation/erosion over a square window of side up to MAX_KERNEL, one
// pixel beat per clock in raster order. Each result leaves R*W + min(R, W-1)
// counted beats after its source pixel (R the radius, W the width); after the
// last pixel of a frame the host sends drain beats until the last result has
// left. The line store is a RAM of MAX_WIDTH words holding flags of the
// previous 2*RMAX rows, read one column ahead; a row of column cells forms the
// window. Throughput is one beat per cycle, limited only by output stall.
// Depends on bdew_pkg, bdew_ram and bdew_cell.
module binary_dilate_erode_window #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_KERNEL = 7
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [bdew_pkg::PIXEL_W-1:0]        i_pixel_in,
    input  logic                                i_drain,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [bdew_pkg::PIXEL_W-1:0]        o_pixel_out,
    output logic [bdew_pkg::COORD_W-1:0]        o_out_col,
    output logic [bdew_pkg::COORD_W-1:0]        o_out_row,
    output logic                                o_frame_last,
    input  logic                                i_cfg_we,
    input  logic [bdew_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [bdew_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import bdew_pkg::*;

    localparam int RMAX = (MAX_KERNEL - 1) / 2;
    localparam int NR   = 2 * RMAX + 1;
    localparam int NL   = 2 * RMAX;
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = CW + 1;
    localparam int XW   = WW + 2;
    localparam int RW   = $clog2(RMAX + 1);
    localparam int DW   = $clog2(RMAX * MAX_WIDTH + RMAX + 1);
    localparam int HW   = CFG_DATA_W;
    localparam int YW   = HW + 1;

    // Configuration
    logic [CFG_DATA_W-1:0] r_cfg_width, r_cfg_height;
    logic [KERNEL_W-1:0]   r_cfg_kernel;
    t_op                   r_cfg_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= RST_WIDTH;
            r_cfg_height <= RST_HEIGHT;
            r_cfg_kernel <= RST_KERNEL;
            r_cfg_mode   <= OP_DILATE;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH:  r_cfg_width  <= i_cfg_data;
                CFG_HEIGHT: r_cfg_height <= i_cfg_data;
                CFG_KERNEL: r_cfg_kernel <= i_cfg_data[KERNEL_W-1:0];
                CFG_MODE:   r_cfg_mode   <= t_op'(i_cfg_data[0]);
                default:    r_cfg_mode   <= r_cfg_mode;
            endcase
        end
    end

    // Effective geometry
    logic [WW-1:0]  w_eff;
    logic [HW-1:0]  h_eff;
    logic [3:0]     k_clamp;
    logic [RW-1:0]  rad;
    logic [RW-1:0]  offs;
    logic [DW-1:0]  delay;

    always_comb begin
        if (r_cfg_width == '0) begin
            w_eff = WW'(1);
        end else if (int'(r_cfg_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_cfg_width);
        end
        if (r_cfg_height == '0) begin
            h_eff = HW'(1);
        end else if (r_cfg_height > HW'(MAX_ROWS)) begin
            h_eff = HW'(MAX_ROWS);
        end else begin
            h_eff = r_cfg_height;
        end
        k_clamp = ({1'b0, r_cfg_kernel} > 4'(MAX_KERNEL)) ? 4'(MAX_KERNEL)
                                                           : {1'b0, r_cfg_kernel};
        rad  = (k_clamp == 4'd0) ? '0 : RW'((k_clamp - 4'd1) >> 1);
        offs = (XW'(rad) < XW'(w_eff) - XW'(1)) ? rad : RW'(w_eff - WW'(1));
        delay = DW'(rad) * DW'(w_eff) + DW'(offs);
    end

    // Handshake and frame control
    logic             r_a_valid, r_b_valid;
    logic [CW-1:0]    r_a_col;
    logic [COORD_W-1:0] r_a_row;
    logic             r_a_last;
    logic [CW-1:0]    r_v_col, n_v_col;
    logic [COORD_W-1:0] r_in_row, n_in_row;
    logic             r_in_done, n_in_done;
    logic [CW-1:0]    r_emit_col, n_emit_col;
    logic [COORD_W-1:0] r_emit_row, n_emit_row;
    logic [DW-1:0]    r_count, n_count;

    logic b_take, in_acc, counted, is_pix, emit_now, emit_last;
    logic [1:0] new_flag;

    assign b_take   = !r_b_valid || !i_stall;
    assign o_stall  = r_a_valid && !b_take;
    assign in_acc   = i_valid && !o_stall;
    assign counted  = in_acc && (r_in_done || !i_drain);
    assign is_pix   = !r_in_done && !i_drain;
    assign emit_now = counted && (r_count >= delay);
    assign emit_last = (YW'(r_emit_row) == YW'(h_eff) - YW'(1))
                    && (XW'(r_emit_col) == XW'(w_eff) - XW'(1));

    always_comb begin
        new_flag = '0;
        if (is_pix) begin
            new_flag[FLAG_ZERO_BIT] = (i_pixel_in == PIX_ZERO);
            new_flag[FLAG_FULL_BIT] = (i_pixel_in == PIX_FULL);
        end
    end

    always_comb begin
        n_v_col    = r_v_col;
        n_in_row   = r_in_row;
        n_in_done  = r_in_done;
        n_emit_col = r_emit_col;
        n_emit_row = r_emit_row;
        n_count    = r_count;
        if (i_cfg_we || (emit_now && emit_last)) begin
            n_v_col    = '0;
            n_in_row   = '0;
            n_in_done  = 1'b0;
            n_emit_col = '0;
            n_emit_row = '0;
            n_count    = '0;
        end else if (counted) begin
            // The column counter keeps running through drain beats so that the
            // window stays aligned with the line store.
            if (XW'(r_v_col) + XW'(1) < XW'(w_eff)) begin
                n_v_col = r_v_col + CW'(1);
            end else begin
                n_v_col = '0;
                if (is_pix) begin
                    if (YW'(r_in_row) + YW'(1) < YW'(h_eff)) begin
                        n_in_row = r_in_row + COORD_W'(1);
                    end else begin
                        n_in_done = 1'b1;
                    end
                end
            end
            if (r_count < delay) begin
                n_count = r_count + DW'(1);
            end
            if (emit_now) begin
                if (XW'(r_emit_col) + XW'(1) < XW'(w_eff)) begin
                    n_emit_col = r_emit_col + CW'(1);
                end else begin
                    n_emit_col = '0;
                    n_emit_row = r_emit_row + COORD_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_col    <= '0;
            r_in_row   <= '0;
            r_in_done  <= 1'b0;
            r_emit_col <= '0;
            r_emit_row <= '0;
            r_count    <= '0;
            r_a_valid  <= 1'b0;
            r_b_valid  <= 1'b0;
        end else begin
            r_v_col    <= n_v_col;
            r_in_row   <= n_in_row;
            r_in_done  <= n_in_done;
            r_emit_col <= n_emit_col;
            r_emit_row <= n_emit_row;
            r_count    <= n_count;
            if (emit_now) begin
                r_a_valid <= 1'b1;
            end else if (b_take) begin
                r_a_valid <= 1'b0;
            end
            if (b_take) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_now) begin
            r_a_col  <= r_emit_col;
            r_a_row  <= r_emit_row;
            r_a_last <= emit_last;
        end
    end

    // Line store: one word per column, the flags of the previous 2*RMAX rows.
    logic [NL-1:0][1:0] ram_q, rd_word, wr_word, r_byp_data;
    logic               r_byp;
    logic [NR-1:0][1:0] push_col;

    bdew_ram #(
        .WIDTH (2 * NL),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (counted),
        .i_waddr (r_v_col),
        .i_wdata (wr_word),
        .i_raddr (n_v_col),
        .o_rdata (ram_q)
    );

    assign rd_word = r_byp ? r_byp_data : ram_q;

    always_comb begin
        wr_word[0]  = new_flag;
        push_col[0] = new_flag;
        for (int j = 1; j < NL; j++) begin
            wr_word[j] = rd_word[j-1];
        end
        for (int j = 0; j < NL; j++) begin
            push_col[j+1] = rd_word[j];
        end
    end

    // A narrow frame reads back the column it is writing; forward it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else begin
            r_byp <= counted && (r_v_col == n_v_col);
        end
        r_byp_data <= wr_word;
    end

    // Window row of cells; cell k holds the column k beats older than the newest.
    t_cell_ctl          cell_ctl;
    logic [NR-1:0][NR-1:0][1:0] cols;
    logic [NR-1:0]      col_ok;
    logic [NR-1:0]      row_ok;
    logic [NR-1:0]      hits;

    assign cell_ctl.shift     = counted;
    assign cell_ctl.want_zero = (r_cfg_mode == OP_ERODE);

    always_comb begin
        logic [YW:0] rr;
        logic [XW-1:0] cm;
        rr = (YW+1)'(r_a_row) + (YW+1)'(rad);
        cm = XW'(r_a_col) + XW'(offs);
        for (int j = 0; j < NR; j++) begin
            row_ok[j] = ((YW+1)'(j) <= rr)
                     && (rr - (YW+1)'(j) < (YW+1)'(h_eff))
                     && ((YW+1)'(j) <= ((YW+1)'(rad) << 1));
        end
        for (int k = 0; k < NR; k++) begin
            col_ok[k] = (XW'(k) <= cm)
                     && (cm - XW'(k) < XW'(w_eff))
                     && (XW'(k) <= XW'(offs) + XW'(rad));
        end
    end

    for (genvar k = 0; k < NR; k++) begin : g_cell
        bdew_cell #(
            .NR (NR)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (cell_ctl),
            .i_col    ((k == 0) ? push_col : cols[(k == 0) ? 0 : k-1]),
            .i_col_ok (col_ok[k]),
            .i_row_ok (row_ok),
            .o_col    (cols[k]),
            .o_hit    (hits[k])
        );
    end

    // Filter result from the window.
    logic [1:0]          center;
    logic                hit;
    logic [PIXEL_W-1:0]  result;

    always_comb begin
        center = '0;
        for (int k = 0; k < NR; k++) begin
            for (int j = 0; j < NR; j++) begin
                if ((RW+1)'(k) == (RW+1)'(offs) && (RW+1)'(j) == (RW+1)'(rad)) begin
                    center = cols[k][j];
                end
            end
        end
        hit = |hits;
        if (r_cfg_mode == OP_DILATE) begin
            result = (!center[FLAG_ZERO_BIT] || hit) ? PIX_FULL : PIX_ZERO;
        end else begin
            result = (!center[FLAG_FULL_BIT] || hit) ? PIX_ZERO : PIX_FULL;
        end
    end

    logic [PIXEL_W-1:0]  r_pix;
    logic [COORD_W-1:0]  r_col_out, r_row_out;
    logic                r_last_out;

    always_ff @(posedge i_clk) begin
        if (b_take) begin
            r_pix      <= result;
            r_col_out  <= COORD_W'(r_a_col);
            r_row_out  <= r_a_row;
            r_last_out <= r_a_last;
        end
    end

    assign o_valid      = r_b_valid;
    assign o_pixel_out  = r_pix;
    assign o_out_col    = r_col_out;
    assign o_out_row    = r_row_out;
    assign o_frame_last = r_last_out;
endmodule

// File: rtl/bdew_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the line store of the window block.
module bdew_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/bdew_cell.sv
// One column cell of the window row: holds a column of pixel flags, passes it
// to its neighbour on every shift and reports whether it sees a wanted flag.
// Depends on bdew_pkg.
module bdew_cell #(
    parameter int NR = 7
) (
    input  logic                   i_clk,
    input  bdew_pkg::t_cell_ctl    i_ctl,
    input  logic [NR-1:0][1:0]     i_col,
    input  logic                   i_col_ok,
    input  logic [NR-1:0]          i_row_ok,
    output logic [NR-1:0][1:0]     o_col,
    output logic                   o_hit
);
    import bdew_pkg::*;

    logic [NR-1:0][1:0] r_col;
    logic [NR-1:0]      sel;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_col <= i_col;
        end
    end

    always_comb begin
        for (int j = 0; j < NR; j++) begin
            sel[j] = i_ctl.want_zero ? r_col[j][FLAG_ZERO_BIT] : r_col[j][FLAG_FULL_BIT];
        end
    end

    assign o_hit = i_col_ok && (|(sel & i_row_ok));
    assign o_col = r_col;
endmodule

// File: rtl/bdew_chk.sv
// Port-level checker for the binary dilate/erode window block, bound to the
// top level. Depends on bdew_pkg.
module bdew_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_stall,
    input logic [bdew_pkg::PIXEL_W-1:0]        i_pixel_in,
    input logic                                i_drain,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic [bdew_pkg::PIXEL_W-1:0]        o_pixel_out,
    input logic [bdew_pkg::COORD_W-1:0]        o_out_col,
    input logic [bdew_pkg::COORD_W-1:0]        o_out_row,
    input logic                                o_frame_last,
    input logic                                i_cfg_we,
    input logic [bdew_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input logic [bdew_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import bdew_pkg::*;

    // The block only holds input back when a result is waiting downstream.
    a_stall_needs_held_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held output beat");

    a_binary_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pixel_out == PIX_ZERO || o_pixel_out == PIX_FULL))
        else $error("output pixel is neither 0 nor 255");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_held_beat_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_pixel_out) && $stable(o_out_col)
                                  && $stable(o_out_row) && $stable(o_frame_last)))
        else $error("stalled output beat changed");
endmodule

bind binary_dilate_erode_window bdew_chk u_bdew_chk (.*);
